FILE: rtl/core/rbds_pkg.sv
// package for the render bin depth sorter
// command codes, bin codes, order and state types and default sizes; no dependencies
`default_nettype none

package rbds_pkg;

  localparam int unsigned ListDepthDef = 64;
  localparam int unsigned ItemBitsDef  = 16;
  localparam int unsigned NumLists     = 7;

  localparam logic [1:0] CmdPush   = 2'd0;
  localparam logic [1:0] CmdRead   = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [2:0] BinOpaque       = 3'd0;
  localparam logic [2:0] BinOpaqueCustom = 3'd1;
  localparam logic [2:0] BinTransl       = 3'd2;
  localparam logic [2:0] BinTranslCustom = 3'd3;
  localparam logic [2:0] BinOccluder     = 3'd4;
  localparam logic [2:0] BinScreen       = 3'd5;
  localparam logic [2:0] BinShadow       = 3'd6;

  typedef enum logic [1:0] {
    OrdFrontToBack,
    OrdBackToFront,
    OrdAppend
  } order_e;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StScan,
    StPlace,
    StRdReq,
    StRdWait,
    StOut
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/render_bin_depth_sorter.sv
// render bin depth sorter top level
// sorted bin lists in one synchronous memory; uses rbds_pkg
//
// usage: one input channel (in_valid_i/in_ready_o) carries a command: push a
// draw item, read one list entry, or clear all lists. one output channel
// (out_valid_o/out_ready_i) returns exactly one result per command.
// a push classifies the item into a bin and appends it, or inserts it by
// walking the list from its tail toward the head, moving one entry per cycle
// through the memory (one read and one write port). a push places its item
// directly when it appends or its list is empty, and writes nothing when the
// list is full (overflow); an opaque item that casts shadows is then also
// inserted front to back into the shadow list. a read skips the memory when
// its bin or index is out of range. the next command is taken only in the
// idle state, which follows the output state.
// the block takes one transaction at a time; a finished result sits in the
// output register so the next command can be accepted while it waits.
// when the receiver stalls with the output register full, the next result
// waits in its final state and no further command is taken.
// reset empties all lists at once (counts cleared); entries are not cleared.
`default_nettype none

module render_bin_depth_sorter #(
  parameter int unsigned LIST_DEPTH = rbds_pkg::ListDepthDef,
  parameter int unsigned ITEM_BITS  = rbds_pkg::ItemBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [15:0] item_id_i,
  input  wire logic        on_screen_i,
  input  wire logic        color_mask_enabled_i,
  input  wire logic [3:0]  channel_masks_i,
  input  wire logic        alpha_enabled_i,
  input  wire logic        has_program_i,
  input  wire logic        casts_shadows_i,
  input  wire logic [31:0] distance_sq_i,
  input  wire logic [2:0]  read_bin_i,
  input  wire logic [5:0]  read_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       bin_o,
  output logic [6:0]       position_o,
  output logic             shadow_added_o,
  output logic [6:0]       shadow_position_o,
  output logic             overflow_o,
  output logic             read_valid_o,
  output logic [15:0]      read_item_o,
  output logic [31:0]      read_distance_o
);

  localparam int unsigned CW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MemD  = rbds_pkg::NumLists * LIST_DEPTH;
  localparam int unsigned AW    = $clog2(MemD);
  localparam int unsigned EW    = ITEM_BITS + 32;
  localparam int unsigned CMPW  = (CW > 6) ? CW : 6;

  rbds_pkg::state_e state_q, state_d;

  logic [ITEM_BITS-1:0] item_q;
  logic [31:0]          dist_q;
  rbds_pkg::order_e     order_q;
  logic                 cast_q;
  logic [2:0]           lst_q;
  logic                 shd_phase_q;
  logic [CW-1:0]        k_q;
  logic [5:0]           ridx_q;
  logic [CW-1:0]        cnt_q [rbds_pkg::NumLists];

  logic [2:0]  res_bin_q;
  logic [6:0]  res_pos_q;
  logic        res_sadd_q;
  logic [6:0]  res_spos_q;
  logic        res_ovf_q;
  logic        res_rvalid_q;
  logic [15:0] res_item_q;
  logic [31:0] res_dist_q;
  logic        out_valid_q;

  logic [EW-1:0] mem [MemD];
  logic [EW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic          accept;
  logic [2:0]    cls_bin;
  rbds_pkg::order_e cls_order;
  logic          cls_cast;
  logic [CW-1:0] cur_cnt;
  logic [AW-1:0] base;
  logic          full, direct, shift, placed, phase_end, rd_ok, out_free;
  logic [EW-1:0] new_entry;
  logic [31:0]   item_wide;

  function automatic logic [CW-1:0] k_placed(input rbds_pkg::state_e st,
                                             input logic [CW-1:0] cnt,
                                             input logic [CW-1:0] k);
    logic [CW-1:0] r;
    case (st)
      rbds_pkg::StStart: r = cnt;
      rbds_pkg::StScan:  r = k;
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cls_cast  = 1'b0;
    cls_order = rbds_pkg::OrdFrontToBack;
    if (on_screen_i) begin
      cls_bin   = rbds_pkg::BinScreen;
      cls_order = rbds_pkg::OrdAppend;
    end else if (color_mask_enabled_i && channel_masks_i != 4'hF) begin
      cls_bin = rbds_pkg::BinOccluder;
    end else if (alpha_enabled_i) begin
      cls_bin   = has_program_i ? rbds_pkg::BinTranslCustom : rbds_pkg::BinTransl;
      cls_order = rbds_pkg::OrdBackToFront;
    end else begin
      cls_bin  = has_program_i ? rbds_pkg::BinOpaqueCustom : rbds_pkg::BinOpaque;
      cls_cast = casts_shadows_i;
    end
  end

  assign item_wide = 32'(item_id_i);
  assign cur_cnt   = (lst_q < 3'(rbds_pkg::NumLists)) ? cnt_q[lst_q] : '0;
  assign base      = AW'(lst_q) * AW'(LIST_DEPTH);
  assign new_entry = {item_q, dist_q};
  assign full      = (cur_cnt == CW'(LIST_DEPTH));
  assign direct    = (order_q == rbds_pkg::OrdAppend) || (cur_cnt == '0);
  assign shift     = (order_q == rbds_pkg::OrdBackToFront) ? (rdata_q[31:0] < dist_q)
                                                             : (rdata_q[31:0] > dist_q);
  assign rd_ok     = (lst_q < 3'(rbds_pkg::NumLists)) && (CMPW'(ridx_q) < CMPW'(cur_cnt));

  always_comb begin
    placed = 1'b0;
    case (state_q)
      rbds_pkg::StStart: placed = !full && direct;
      rbds_pkg::StScan:  placed = !shift;
      rbds_pkg::StPlace: placed = 1'b1;
      default:           placed = 1'b0;
    endcase
  end

  assign phase_end = placed || (state_q == rbds_pkg::StStart && full);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbds_pkg::StIdle: begin
        if (accept) begin
          case (cmd_i)
            rbds_pkg::CmdPush: state_d = rbds_pkg::StStart;
            rbds_pkg::CmdRead: state_d = rbds_pkg::StRdReq;
            default:           state_d = rbds_pkg::StOut;
          endcase
        end
      end
      rbds_pkg::StStart: begin
        if (!full && !direct) state_d = rbds_pkg::StScan;
      end
      rbds_pkg::StScan: begin
        if (shift && k_q == CW'(1)) state_d = rbds_pkg::StPlace;
      end
      rbds_pkg::StRdReq:  state_d = rd_ok ? rbds_pkg::StRdWait : rbds_pkg::StOut;
      rbds_pkg::StRdWait: state_d = rbds_pkg::StOut;
      rbds_pkg::StOut: begin
        if (out_free) state_d = rbds_pkg::StIdle;
      end
      default: state_d = state_q;
    endcase
    if (phase_end) begin
      state_d = (!shd_phase_q && cast_q) ? rbds_pkg::StStart : rbds_pkg::StOut;
    end
  end

  // memory control
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = base;
    raddr      = base;
    wdata      = new_entry;
    case (state_q)
      rbds_pkg::StIdle: in_ready_o = 1'b1;
      rbds_pkg::StStart: begin
        if (!full && direct) begin
          mem_we = 1'b1;
          waddr  = base + AW'(cur_cnt);
        end else if (!full) begin
          mem_re = 1'b1;
          raddr  = base + AW'(cur_cnt) - AW'(1);
        end
      end
      rbds_pkg::StScan: begin
        mem_we = 1'b1;
        waddr  = base + AW'(k_q);
        if (shift) begin
          wdata = rdata_q;
          if (k_q != CW'(1)) begin
            mem_re = 1'b1;
            raddr  = base + AW'(k_q) - AW'(2);
          end
        end
      end
      rbds_pkg::StPlace: mem_we = 1'b1;
      rbds_pkg::StRdReq: begin
        mem_re = rd_ok;
        raddr  = base + AW'(ridx_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbds_pkg::StIdle;
      out_valid_q <= 1'b0;
      shd_phase_q <= 1'b0;
      for (int i = 0; i < int'(rbds_pkg::NumLists); i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == rbds_pkg::StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        shd_phase_q <= 1'b0;
        if (cmd_i == rbds_pkg::CmdClear) begin
          for (int i = 0; i < int'(rbds_pkg::NumLists); i++) cnt_q[i] <= '0;
        end
      end
      if (placed) cnt_q[lst_q] <= cur_cnt + CW'(1);
      if (phase_end && !shd_phase_q && cast_q) shd_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q       <= item_wide[ITEM_BITS-1:0];
      dist_q       <= distance_sq_i;
      order_q      <= cls_order;
      cast_q       <= (cmd_i == rbds_pkg::CmdPush) && cls_cast;
      lst_q        <= (cmd_i == rbds_pkg::CmdPush) ? cls_bin : read_bin_i;
      ridx_q       <= read_index_i;
      res_bin_q    <= (cmd_i == rbds_pkg::CmdPush) ? cls_bin : 3'd0;
      res_pos_q    <= '0;
      res_sadd_q   <= 1'b0;
      res_spos_q   <= '0;
      res_ovf_q    <= 1'b0;
      res_rvalid_q <= 1'b0;
      res_item_q   <= '0;
      res_dist_q   <= '0;
    end
    if (state_q == rbds_pkg::StStart) begin
      k_q <= cur_cnt;
      if (full) res_ovf_q <= 1'b1;
    end
    if (state_q == rbds_pkg::StScan && shift) k_q <= k_q - CW'(1);
    if (placed) begin
      if (shd_phase_q) begin
        res_sadd_q <= 1'b1;
        res_spos_q <= 7'(k_placed(state_q, cur_cnt, k_q));
      end else begin
        res_pos_q <= 7'(k_placed(state_q, cur_cnt, k_q));
      end
    end
    if (phase_end && !shd_phase_q && cast_q) begin
      lst_q   <= rbds_pkg::BinShadow;
      order_q <= rbds_pkg::OrdFrontToBack;
    end
    if (state_q == rbds_pkg::StRdWait) begin
      res_rvalid_q <= 1'b1;
      res_item_q   <= 16'(32'(rdata_q[EW-1:32]));
      res_dist_q   <= rdata_q[31:0];
    end
    if (state_q == rbds_pkg::StOut && out_free) begin
      bin_o             <= res_bin_q;
      position_o        <= res_pos_q;
      shadow_added_o    <= res_sadd_q;
      shadow_position_o <= res_spos_q;
      overflow_o        <= res_ovf_q;
      read_valid_o      <= res_rvalid_q;
      read_item_o       <= res_item_q;
      read_distance_o   <= res_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rbds_pkg::StIdle) |-> (cur_cnt <= CW'(LIST_DEPTH)))
    else $error("list count above depth");
  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (waddr - base) <= AW'(cur_cnt))
    else $error("write beyond list tail");
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbds_pkg::StStart && full) |-> !mem_we && !mem_re)
    else $error("memory access on full list");
  a_scan_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbds_pkg::StScan) |-> (k_q != '0))
    else $error("scan with empty prefix");
`endif

endmodule

`default_nettype wire
